/* design/crbg_pkg.sv */
// Shared constants, codes and control types of the counter-based random generator.
package crbg_pkg;

    // Batch geometry
    localparam int ROUNDS   = 10;
    localparam int CHANNELS = 4;
    localparam int LANES    = 4;
    localparam int BLOCKS   = 2;
    localparam int BATCH    = LANES * CHANNELS;
    localparam int BATCH_W  = $clog2(BATCH);
    localparam int POS_W    = $clog2(BATCH + 1);
    localparam int ROUND_W  = $clog2(ROUNDS + 1);

    // Word widths
    localparam int WORD_W    = 64;
    localparam int HALF_W    = 32;
    localparam int CFG_IDX_W = 3;

    // Round multipliers and key schedule increments
    localparam logic [HALF_W-1:0] MUL_A  = 32'hCD9E8D57;
    localparam logic [HALF_W-1:0] MUL_B  = 32'hD2511F53;
    localparam logic [HALF_W-1:0] WEYL_A = 32'hBB67AE85;
    localparam logic [HALF_W-1:0] WEYL_B = 32'h9E2779B9;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_LANE0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_LANE1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_LANE2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_LANE3 = 3'd5;

    // Controller to datapath commands
    typedef struct packed {
        logic start_refill;  // load counters into mixer, reset batch position
        logic step_round;    // run one mixing round on every block
        logic take_word;     // move current batch word to the output register
    } crbg_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic batch_empty;
    } crbg_sts_t;

endpackage

/* design/crbg_datapath.sv */
// Datapath: key and counter registers, mixing rounds for all channels, batch readout.
module crbg_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  crbg_pkg::crbg_cmd_t             cmd,
    output crbg_pkg::crbg_sts_t             sts,
    input  logic                            cfg_we,
    input  logic [crbg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crbg_pkg::WORD_W-1:0]     cfg_data,
    output logic [crbg_pkg::WORD_W-1:0]     word_out
);
    import crbg_pkg::*;

    // Architectural state
    logic [WORD_W-1:0] key_low_reg;
    logic [WORD_W-1:0] key_high_reg;
    logic [WORD_W-1:0] counter_reg [LANES];
    logic [POS_W-1:0]  pos_reg;

    // Mixer working state, one set of four words per channel and block
    logic [HALF_W-1:0] w_reg  [CHANNELS][BLOCKS][4];
    logic [HALF_W-1:0] ka_reg [BLOCKS];
    logic [HALF_W-1:0] kb_reg [BLOCKS];
    logic [WORD_W-1:0] out_reg;

    // Round results and load values
    logic [WORD_W-1:0] p_prod   [CHANNELS][BLOCKS];
    logic [WORD_W-1:0] q_prod   [CHANNELS][BLOCKS];
    logic [HALF_W-1:0] w_round  [CHANNELS][BLOCKS][4];
    logic [WORD_W-1:0] lane_in  [CHANNELS][LANES];
    logic [WORD_W-1:0] batch_word [BATCH];

    // One round per block: two 32x32 products, then swap and key mix
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            for (int b = 0; b < BLOCKS; b++)
            begin
                p_prod[c][b] = WORD_W'(w_reg[c][b][0]) * WORD_W'(MUL_A);
                q_prod[c][b] = WORD_W'(w_reg[c][b][2]) * WORD_W'(MUL_B);
                w_round[c][b][0] = q_prod[c][b][WORD_W-1:HALF_W] ^ w_reg[c][b][3] ^ kb_reg[b];
                w_round[c][b][1] = p_prod[c][b][HALF_W-1:0];
                w_round[c][b][2] = p_prod[c][b][WORD_W-1:HALF_W] ^ w_reg[c][b][1] ^ ka_reg[b];
                w_round[c][b][3] = q_prod[c][b][HALF_W-1:0];
            end
        end
    end

    // Channel c sees every counter lane offset by c
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            for (int j = 0; j < LANES; j++)
            begin
                lane_in[c][j] = counter_reg[j] + WORD_W'(c);
            end
        end
    end

    // Batch word 4c+j is lane j of channel c, high word on top
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            for (int b = 0; b < BLOCKS; b++)
            begin
                batch_word[LANES*c + 2*b]     = {w_reg[c][b][1], w_reg[c][b][0]};
                batch_word[LANES*c + 2*b + 1] = {w_reg[c][b][3], w_reg[c][b][2]};
            end
        end
    end

    // Mixer and output registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.start_refill)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                for (int b = 0; b < BLOCKS; b++)
                begin
                    w_reg[c][b][0] <= lane_in[c][2*b][HALF_W-1:0];
                    w_reg[c][b][1] <= lane_in[c][2*b][WORD_W-1:HALF_W];
                    w_reg[c][b][2] <= lane_in[c][2*b+1][HALF_W-1:0];
                    w_reg[c][b][3] <= lane_in[c][2*b+1][WORD_W-1:HALF_W];
                end
            end
            ka_reg[0] <= key_low_reg[HALF_W-1:0];
            kb_reg[0] <= key_low_reg[WORD_W-1:HALF_W];
            ka_reg[1] <= key_high_reg[HALF_W-1:0];
            kb_reg[1] <= key_high_reg[WORD_W-1:HALF_W];
        end
        else if (cmd.step_round)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                for (int b = 0; b < BLOCKS; b++)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        w_reg[c][b][k] <= w_round[c][b][k];
                    end
                end
            end
            // key bump after the last round is harmless: reloaded on next refill
            for (int b = 0; b < BLOCKS; b++)
            begin
                ka_reg[b] <= ka_reg[b] + WEYL_A;
                kb_reg[b] <= kb_reg[b] + WEYL_B;
            end
        end

        if (cmd.take_word)
        begin
            out_reg <= batch_word[pos_reg[BATCH_W-1:0]];
        end
    end

    // Keys, counters and batch position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            for (int j = 0; j < LANES; j++)
            begin
                counter_reg[j] <= '0;
            end
            pos_reg <= POS_W'(BATCH);
        end
        else
        begin
            if (cmd.start_refill)
            begin
                for (int j = 0; j < LANES; j++)
                begin
                    counter_reg[j] <= counter_reg[j] + WORD_W'(CHANNELS);
                end
                pos_reg <= '0;
            end
            else if (cmd.take_word)
            begin
                pos_reg <= pos_reg + POS_W'(1);
            end

            // any write to a mapped register empties the batch
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_KEY_LOW:
                    begin
                        key_low_reg <= cfg_data;
                        pos_reg     <= POS_W'(BATCH);
                    end
                    REG_KEY_HIGH:
                    begin
                        key_high_reg <= cfg_data;
                        pos_reg      <= POS_W'(BATCH);
                    end
                    REG_SEED_LANE0:
                    begin
                        counter_reg[0] <= cfg_data;
                        pos_reg        <= POS_W'(BATCH);
                    end
                    REG_SEED_LANE1:
                    begin
                        counter_reg[1] <= cfg_data;
                        pos_reg        <= POS_W'(BATCH);
                    end
                    REG_SEED_LANE2:
                    begin
                        counter_reg[2] <= cfg_data;
                        pos_reg        <= POS_W'(BATCH);
                    end
                    REG_SEED_LANE3:
                    begin
                        counter_reg[3] <= cfg_data;
                        pos_reg        <= POS_W'(BATCH);
                    end
                    default:
                    begin
                        // unmapped index: ignored
                    end
                endcase
            end
        end
    end

    assign sts.batch_empty = (pos_reg == POS_W'(BATCH));
    assign word_out        = out_reg;

endmodule

/* design/crbg_ctrl.sv */
// Controller: request handshake, refill round sequencer and output valid.
module crbg_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  request,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  crbg_pkg::crbg_sts_t   sts,
    output crbg_pkg::crbg_cmd_t   cmd
);
    import crbg_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MIX  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [ROUND_W-1:0] round_reg;
    logic [ROUND_W-1:0] round_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               accept;

    // Take a word only when idle and the output slot is free or draining
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && request)
                begin
                    if (sts.batch_empty)
                    begin
                        cmd.start_refill = 1'b1;
                        round_next       = '0;
                        state_next       = ST_MIX;
                    end
                    else
                    begin
                        cmd.take_word = 1'b1;
                    end
                end
            end
            ST_MIX:
            begin
                cmd.step_round = 1'b1;
                if (round_reg == ROUND_W'(ROUNDS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    round_next = round_reg + ROUND_W'(1);
                end
            end
            ST_DONE:
            begin
                cmd.take_word = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on a new word, cleared when taken
    always_comb
    begin
        if (cmd.take_word)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

/* design/counter_based_random_generator_top.sv */
// Top level of the counter-based random generator: controller plus datapath.
// A word from a filled batch is registered and presented in the cycle after its request is taken;
// a request that finds the batch empty first goes through load, the mixing rounds and readout.
// Throughput: one word per cycle inside a batch while the output is not stalled by m_tready;
// the refilling word waits for the rounds on the 16 parallel round multipliers.
// Reset: keys and counters clear to 0, batch marked empty, output not valid.
module counter_based_random_generator_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [0] request, [7:1] zero
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [crbg_pkg::WORD_W-1:0]     m_tdata,   // [63:0] random_word
    input  logic                            cfg_we,
    input  logic [crbg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crbg_pkg::WORD_W-1:0]     cfg_data
);
    import crbg_pkg::*;

    crbg_cmd_t cmd;
    crbg_sts_t sts;

    crbg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .request  (s_tdata[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    crbg_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .word_out  (m_tdata)
    );

    // A refill only starts on an empty batch
    a_refill_on_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_refill |-> sts.batch_empty)
        else $error("refill started with words left in the batch");

    // The refill word is read out right after the last round
    a_refill_length: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_refill |-> ##(ROUNDS + 1) cmd.take_word)
        else $error("refill did not deliver its word on time");

    // After a refill the batch is no longer empty
    a_refill_fills: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_refill |=> !sts.batch_empty)
        else $error("batch still empty after refill start");

    // A word read from the batch is presented on the next cycle
    a_word_presented: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_word |=> m_tvalid)
        else $error("word taken from batch but output not valid");

    // No new request is taken while rounds are running
    a_no_accept_in_refill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_round |-> !s_tready)
        else $error("input ready during mixing rounds");

endmodule

/* tb/tb_counter_based_random_generator_top.sv */
// Self-checking testbench for the counter-based random generator: stream driver, monitor, predictor.
module tb_counter_based_random_generator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import crbg_pkg::*;

    // Indexes that decode to no register
    localparam logic [CFG_IDX_W-1:0] REG_NONE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_B = 3'd7;

    localparam int RESET_CYCLES  = 12;
    localparam int DRAIN_CYCLES  = 24;     // refill latency plus margin
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_WORDS   = 120;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;    // [0] request, [7:1] zero
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [WORD_W-1:0]    m_tdata;         // [63:0] random_word
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data = '0;

    // Predictor state
    logic [WORD_W-1:0] key_low_q;
    logic [WORD_W-1:0] key_high_q;
    logic [WORD_W-1:0] lane_q [LANES];
    logic [WORD_W-1:0] batch_q [BATCH];
    int                batch_pos;

    // Request bits waiting to be sent, words waiting to come back
    logic              request_queue [$];
    logic [WORD_W-1:0] awaited_words [$];

    int                send_idle_pct = 21;
    int                recv_stall_pct = 47;
    int                error_count = 0;
    int                cycle_count = 0;
    logic [WORD_W-1:0] want_word;

    counter_based_random_generator_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Ten rounds on one lane pair; returns {lane_b, lane_a}
    function automatic logic [2*WORD_W-1:0] mix_pair(input logic [WORD_W-1:0] lane_a,
                                                     input logic [WORD_W-1:0] lane_b,
                                                     input logic [WORD_W-1:0] key);
        logic [HALF_W-1:0] w0, w1, w2, w3, ka, kb, n0, n2;
        logic [WORD_W-1:0] p, q;
        int r;
        w0 = lane_a[HALF_W-1:0];
        w1 = lane_a[WORD_W-1:HALF_W];
        w2 = lane_b[HALF_W-1:0];
        w3 = lane_b[WORD_W-1:HALF_W];
        ka = key[HALF_W-1:0];
        kb = key[WORD_W-1:HALF_W];
        for (r = 0; r < ROUNDS; r++)
        begin
            p  = {32'b0, w0} * {32'b0, MUL_A};
            q  = {32'b0, w2} * {32'b0, MUL_B};
            n0 = q[WORD_W-1:HALF_W] ^ w3 ^ kb;
            n2 = p[WORD_W-1:HALF_W] ^ w1 ^ ka;
            w0 = n0;
            w1 = p[HALF_W-1:0];
            w2 = n2;
            w3 = q[HALF_W-1:0];
            // key bump after the last round is never used
            ka = ka + WEYL_A;
            kb = kb + WEYL_B;
        end
        return {w3, w2, w1, w0};
    endfunction

    // Refill the whole batch from the counter lanes, then advance them
    task automatic refill_batch();
        logic [WORD_W-1:0]   l [LANES];
        logic [2*WORD_W-1:0] mixed;
        int c, j;
        for (c = 0; c < CHANNELS; c++)
        begin
            for (j = 0; j < LANES; j++)
                l[j] = lane_q[j] + WORD_W'(c);
            mixed = mix_pair(l[0], l[1], key_low_q);
            l[0]  = mixed[WORD_W-1:0];
            l[1]  = mixed[2*WORD_W-1:WORD_W];
            mixed = mix_pair(l[2], l[3], key_high_q);
            l[2]  = mixed[WORD_W-1:0];
            l[3]  = mixed[2*WORD_W-1:WORD_W];
            for (j = 0; j < LANES; j++)
                batch_q[LANES*c + j] = l[j];
        end
        for (j = 0; j < LANES; j++)
            lane_q[j] = lane_q[j] + WORD_W'(CHANNELS);
        batch_pos = 0;
    endtask

    // One accepted request word: queue the word it must return
    task automatic predict_request(input logic request);
        if (request)
        begin
            if (batch_pos >= BATCH)
                refill_batch();
            awaited_words.push_back(batch_q[batch_pos]);
            batch_pos++;
        end
    endtask

    // Register write as seen by the predictor
    task automatic track_config(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        case (idx)
            REG_KEY_LOW:
            begin
                key_low_q = value;
                batch_pos = BATCH;
            end
            REG_KEY_HIGH:
            begin
                key_high_q = value;
                batch_pos = BATCH;
            end
            REG_SEED_LANE0, REG_SEED_LANE1, REG_SEED_LANE2, REG_SEED_LANE3:
            begin
                lane_q[idx - REG_SEED_LANE0] = value;
                batch_pos = BATCH;
            end
            default: ;
        endcase
    endtask

    // Write one register; block must be idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        track_config(idx, value);
    endtask

    // Wait until every word is back, then let a refill run out
    task automatic settle();
        while (request_queue.size() != 0 || s_tvalid || awaited_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random half the time, else an extreme or a value near counter wrap
    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(5));
            3:       return 64'h0000_0000_FFFF_FFFF - 64'($urandom_range(3));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Run-time guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_counter_based_random_generator_top: errors");
            $finish;
        end
    end

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_request(s_tdata[0]);
            if (!s_tvalid || s_tready)
            begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'b0, request_queue.pop_front()};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Word monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_tvalid && m_tready)
            begin
                if (awaited_words.size() == 0)
                begin
                    $error("random_word: no word expected, actual %h", m_tdata);
                    error_count++;
                end
                else
                begin
                    want_word = awaited_words.pop_front();
                    if (m_tdata !== want_word)
                    begin
                        $error("random_word mismatch: expected %h, actual %h", want_word, m_tdata);
                        error_count++;
                    end
                end
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        int phase, counted, chunk, writes, k;
        logic [CFG_IDX_W-1:0] idx;

        key_low_q  = '0;
        key_high_q = '0;
        for (k = 0; k < LANES; k++)
            lane_q[k] = '0;
        batch_pos = BATCH;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings, one idle request in between
        request_queue = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        settle();

        // All-ones keys, counters at the wrap point, writes to unused indexes
        write_reg(REG_KEY_LOW, '1);
        write_reg(REG_KEY_HIGH, '1);
        write_reg(REG_SEED_LANE0, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_SEED_LANE1, 64'hFFFF_FFFF_FFFF_FFFE);
        write_reg(REG_SEED_LANE2, 64'h0000_0000_FFFF_FFFF);
        write_reg(REG_SEED_LANE3, 64'h7FFF_FFFF_FFFF_FFFD);
        write_reg(REG_NONE_A, {$urandom, $urandom});
        write_reg(REG_NONE_B, '1);
        // crosses a batch boundary
        for (k = 0; k < 18; k++)
            request_queue.push_back(1'b1);
        settle();

        // Key change in mid-batch forces a refill
        write_reg(REG_KEY_LOW, 64'h0000_0000_FFFF_FFFF);
        request_queue = '{1'b1, 1'b1};
        settle();

        // Random phases: sender/receiver idling swapped, then none
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct  = (phase == 0) ? 21 : (phase == 1) ? 47 : 0;
            recv_stall_pct = (phase == 0) ? 47 : (phase == 1) ? 21 : 0;
            for (k = 0; k < 6; k++)
                write_reg(REG_KEY_LOW + CFG_IDX_W'(k), pick_value());
            counted = 0;
            while (counted < PHASE_WORDS)
            begin
                writes = $urandom_range(2);
                for (k = 0; k < writes; k++)
                begin
                    idx = CFG_IDX_W'($urandom_range(7));
                    write_reg(idx, pick_value());
                end
                chunk = $urandom_range(4, 40);
                for (k = 0; k < chunk; k++)
                begin
                    if ($urandom_range(15) == 0)
                        request_queue.push_back(1'b0);
                    else
                    begin
                        request_queue.push_back(1'b1);
                        counted++;
                    end
                end
                settle();
            end
        end

        // Drain, bounded
        k = 0;
        while ((request_queue.size() != 0 || s_tvalid || awaited_words.size() != 0) && k < 5000)
        begin
            @(posedge clk);
            k++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (awaited_words.size() != 0)
        begin
            $error("random_word: %0d expected words never arrived", awaited_words.size());
            error_count++;
        end

        if (error_count == 0)
            $display("tb_counter_based_random_generator_top: clean");
        else
            $display("tb_counter_based_random_generator_top: errors");
        $finish;
    end

endmodule
